### rtl/scfr_pkg.sv
// package: types and constants of the sensor command frame responder
package scfr_pkg;

    localparam int unsigned ResultLimit = 54;

    localparam logic [7:0] ChA    = 8'h41;
    localparam logic [7:0] ChP    = 8'h50;
    localparam logic [7:0] ChL    = 8'h4C;
    localparam logic [7:0] ChR    = 8'h52;
    localparam logic [7:0] ChT    = 8'h74;
    localparam logic [7:0] ChH    = 8'h68;
    localparam logic [7:0] ChC    = 8'h63;
    localparam logic [7:0] ChZero = 8'h30;
    localparam logic [7:0] ChHash = 8'h23;
    localparam logic [7:0] ChBang = 8'h21;
    localparam logic [7:0] ChPlus = 8'h2B;
    localparam logic [7:0] ChMin  = 8'h2D;

    localparam logic [1:0] StOk     = 2'd0;
    localparam logic [1:0] StSum    = 2'd1;
    localparam logic [1:0] StEnd    = 2'd2;
    localparam logic [1:0] StUnkn   = 2'd3;

    localparam logic RegStart = 1'b0;
    localparam logic RegEnd   = 1'b1;

    typedef enum logic [2:0] {
        PH_HUNT = 3'd0,
        PH_CMD  = 3'd1,
        PH_SID  = 3'd2,
        PH_D0   = 3'd3,
        PH_D1   = 3'd4,
        PH_D2   = 3'd5,
        PH_END  = 3'd6
    } t_phase;

    // kind of one response field queued for the emitter
    typedef enum logic [2:0] {
        FK_CHAR   = 3'd0,
        FK_SIGNED = 3'd1,
        FK_CO2    = 3'd2,
        FK_SUM    = 3'd3
    } t_fkind;

    // split a value below 256 into three decimal digits
    function automatic logic [11:0] dec3(input logic [7:0] v);
        logic [3:0]  h;
        logic [7:0]  r;
        logic [3:0]  t;
        logic [15:0] p;
        logic [7:0]  o;
        begin
            h = (v >= 8'd200) ? 4'd2 : (v >= 8'd100) ? 4'd1 : 4'd0;
            r = v - ((h == 4'd2) ? 8'd200 : (h == 4'd1) ? 8'd100 : 8'd0);
            // reciprocal multiply, exact below 1029
            p = {8'd0, r} * 16'd205;
            t = 4'(p >> 11);
            o = r - ({4'd0, t} * 8'd10);
            dec3 = {h, t, o[3:0]};
        end
    endfunction

    function automatic logic [7:0] sat99(input logic signed [7:0] v);
        sat99 = (v > 8'sd99) ? 8'sd99 : (v < -8'sd99) ? -8'sd99 : v;
    endfunction

endpackage

### rtl/scfr_if.sv
// interfaces: valid/ready stream channels and the register write channel
interface scfr_in_if;
    logic        valid;
    logic        ready;
    logic [7:0]  rx_byte;
    logic signed [7:0] temperature;
    logic signed [7:0] humidity;
    logic [14:0] co2_level;
    modport source (output valid, rx_byte, temperature, humidity, co2_level, input ready);
    modport sink   (input valid, rx_byte, temperature, humidity, co2_level, output ready);
endinterface

interface scfr_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] tx_byte;
    logic [1:0] status;
    logic       last;
    modport source (output valid, tx_byte, status, last, input ready);
    modport sink   (input valid, tx_byte, status, last, output ready);
endinterface

interface scfr_cfg_if;
    logic       valid;
    logic       ready;
    logic       index;
    logic [7:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### rtl/scfr_digit.sv
// shared digit unit: decimal digits of a value, most significant first, by repeated subtraction; a load restarts it
module scfr_digit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_load,
    input  logic [14:0] i_value,
    input  logic [13:0] i_power,
    input  logic        i_step,
    output logic [3:0]  o_digit,
    output logic        o_done
);
    import scfr_pkg::*;

    logic [14:0] r_rem, n_rem;
    logic [13:0] r_pow, n_pow;
    logic [3:0]  r_dig, n_dig;
    logic        r_busy, n_busy;

    always_comb begin
        n_rem  = r_rem;
        n_pow  = r_pow;
        n_dig  = r_dig;
        n_busy = r_busy;
        if (i_load) begin
            n_rem  = i_value;
            n_pow  = i_power;
            n_dig  = '0;
            n_busy = 1'b1;
        end else if (r_busy && r_rem >= {1'b0, r_pow}) begin
            n_rem = r_rem - {1'b0, r_pow};
            n_dig = r_dig + 4'd1;
        end else if (i_step) begin
            n_dig = '0;
            unique case (r_pow)
                14'd10000: n_pow = 14'd1000;
                14'd1000:  n_pow = 14'd100;
                14'd100:   n_pow = 14'd10;
                14'd10:    n_pow = 14'd1;
                default:   n_busy = 1'b0;
            endcase
        end
    end

    assign o_digit = r_dig;
    assign o_done  = r_busy && (r_rem < {1'b0, r_pow});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else begin
            r_busy <= n_busy;
        end
        r_rem <= n_rem;
        r_pow <= n_pow;
        r_dig <= n_dig;
    end
endmodule

### rtl/sensor_command_frame_responder_unit.sv
// top level: frame parser, history rings and response sequencer
//   channel | dir | fields
//   in      | in  | rx_byte, temperature, humidity, co2_level
//   out     | out | tx_byte, status, last
//   cfg     | in  | index (0 start symbol, 1 end symbol), data
// a byte that gives no response leaves the sequencer idle; an error word is
// registered from the error state once the output is free; a response is the
// frame open byte, then each field in turn, with the decimal digits of signed
// and CO2 fields counted out by the shared digit unit
// input ready only while the sequencer is idle and no output word is pending; output stalls hold the word
// synchronous reset clears parser and rings and sets the symbol registers to '#' and '!'
module sensor_command_frame_responder_unit #(
    parameter int unsigned HISTORY_DEPTH = 3
) (
    input  logic i_clk,
    input  logic i_rst_n,
    scfr_in_if.sink    in_ch,
    scfr_out_if.source out_ch,
    scfr_cfg_if.sink   cfg_ch
);
    import scfr_pkg::*;

    localparam int unsigned SW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_ITEM  = 7'b0000010,
        S_LOAD  = 7'b0000100,
        S_DIG   = 7'b0001000,
        S_OUT   = 7'b0010000,
        S_NEXT  = 7'b0100000,
        S_ERR   = 7'b1000000
    } t_state;

    // response field list, one entry per program step
    localparam int unsigned MaxF = 32;
    t_fkind      r_fk   [MaxF];
    logic [14:0] r_fv   [MaxF];
    logic [5:0]  r_nf, r_fi;

    t_state      r_st;
    t_phase      r_ph;
    logic [7:0]  r_start, r_end, r_cmd, r_sid;
    logic [23:0] r_digits;
    logic [7:0]  r_tr [HISTORY_DEPTH];
    logic [7:0]  r_hr [HISTORY_DEPTH];
    logic [14:0] r_cr [HISTORY_DEPTH];
    logic [SW-1:0] r_ts, r_hs, r_cs;
    logic [7:0]  r_sum;
    logic [5:0]  r_cnt;
    logic [2:0]  r_sub;
    logic [7:0]  r_ob;
    logic [1:0]  r_ost;
    logic        r_olast, r_ovalid;
    logic [11:0] r_d3;

    logic        dig_load, dig_step, dig_done;
    logic [3:0]  dig_val;
    logic [14:0] dig_in;
    logic [13:0] dig_pow;

    scfr_digit u_digit (
        .i_clk, .i_rst_n,
        .i_load(dig_load), .i_value(dig_in), .i_power(dig_pow),
        .i_step(dig_step), .o_digit(dig_val), .o_done(dig_done)
    );

    function automatic logic [SW-1:0] nxt(input logic [SW-1:0] s);
        nxt = (32'(s) + 1 >= HISTORY_DEPTH) ? '0 : SW'(32'(s) + 1);
    endfunction

    // ring entry j places after slot s
    function automatic logic [SW-1:0] ring_at(input logic [SW-1:0] s, input int unsigned j);
        logic [SW+1:0] k;
        k = (SW+2)'(s) + (SW+2)'(j);
        ring_at = (k >= (SW+2)'(HISTORY_DEPTH)) ? SW'(k - (SW+2)'(HISTORY_DEPTH)) : SW'(k);
    endfunction

    logic in_acc, cfg_acc, out_acc, free, emit_w;
    assign free    = !r_ovalid || out_ch.ready;
    assign in_acc  = in_ch.valid && in_ch.ready;
    assign cfg_acc = cfg_ch.valid && cfg_ch.ready;
    assign out_acc = out_ch.valid && out_ch.ready;
    assign emit_w  = free && (r_st == S_ERR || r_st == S_NEXT || r_st == S_OUT);
    assign in_ch.ready  = (r_st == S_IDLE) && !r_ovalid;
    assign cfg_ch.ready = 1'b1;
    assign out_ch.valid   = r_ovalid;
    assign out_ch.tx_byte = r_ob;
    assign out_ch.status  = r_ost;
    assign out_ch.last    = r_olast;

    // current field
    t_fkind      fk;
    logic [14:0] fv;
    logic        is_final;
    assign fk = r_fk[r_fi[4:0]];
    assign fv = r_fv[r_fi[4:0]];
    // number of bytes of the current field
    logic [2:0] flen;
    always_comb begin
        unique case (fk)
            FK_CHAR:   flen = 3'd1;
            FK_SIGNED: flen = 3'd3;
            FK_CO2:    flen = 3'd6;
            default:   flen = 3'd4;
        endcase
    end
    logic [5:0] cnt_n;
    assign cnt_n = r_cnt + 6'd1;
    assign is_final = (cnt_n == 6'(ResultLimit)) ||
        ((r_fi + 6'd1 == r_nf) && (r_sub + 3'd1 == flen));

    logic [7:0] mag;
    assign mag = fv[7] ? 8'(-fv[7:0]) : fv[7:0];

    assign dig_load = (r_st == S_LOAD);
    assign dig_in   = (fk == FK_CO2) ? fv : {7'd0, mag};
    assign dig_pow  = (fk == FK_CO2) ? 14'd10000 : 14'd10;
    assign dig_step = (r_st == S_OUT) && free && (r_sub != 3'd0);

    logic [7:0] ob;
    logic       body;
    always_comb begin
        ob = ChZero;
        body = 1'b1;
        unique case (fk)
            FK_CHAR: ob = fv[7:0];
            FK_SIGNED: ob = (r_sub == 3'd0) ? (fv[7] ? ChMin : ChPlus)
                                            : (ChZero + 8'(dig_val));
            FK_CO2: ob = (r_sub == 3'd0) ? ChPlus : (ChZero + 8'(dig_val));
            default: begin
                body = 1'b0;
                unique case (r_sub)
                    3'd0: ob = ChZero + 8'(r_d3[11:8]);
                    3'd1: ob = ChZero + 8'(r_d3[7:4]);
                    3'd2: ob = ChZero + 8'(r_d3[3:0]);
                    default: ob = ChBang;
                endcase
            end
        endcase
    end

    logic [7:0] t_in, h_in;
    assign t_in = sat99(in_ch.temperature);
    assign h_in = sat99(in_ch.humidity);

    logic [7:0] want_sum;
    logic [11:0] want_d;
    assign want_sum = r_cmd + ((r_cmd == ChP) ? r_sid : 8'd0);
    assign want_d   = dec3(want_sum);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
            r_ph <= PH_HUNT;
            r_start <= 8'd35;
            r_end <= 8'd33;
            r_cmd <= '0;
            r_sid <= '0;
            r_digits <= '0;
            r_ts <= '0; r_hs <= '0; r_cs <= '0;
            for (int i = 0; i < HISTORY_DEPTH; i++) begin
                r_tr[i] <= '0; r_hr[i] <= '0; r_cr[i] <= '0;
            end
            r_ovalid <= 1'b0;
            r_nf <= '0;
        end else begin
            if (out_acc && !emit_w) r_ovalid <= 1'b0;
            if (cfg_acc) begin
                if (cfg_ch.index == RegStart) r_start <= cfg_ch.data;
                else r_end <= cfg_ch.data;
            end
            unique case (r_st)
                S_IDLE: if (in_acc && in_ch.rx_byte != 8'd0) begin
                    unique case (r_ph)
                        PH_HUNT: if (in_ch.rx_byte == r_start) r_ph <= PH_CMD;
                        PH_CMD: begin
                            r_digits <= '0;
                            if (in_ch.rx_byte == ChA || in_ch.rx_byte == ChL ||
                                in_ch.rx_byte == ChR) begin
                                r_cmd <= in_ch.rx_byte;
                                r_ph <= PH_D0;
                            end else if (in_ch.rx_byte == ChP) begin
                                r_cmd <= in_ch.rx_byte;
                                r_ph <= PH_SID;
                            end else begin
                                r_ph <= PH_HUNT;
                                r_ost <= StUnkn;
                                r_st <= S_ERR;
                            end
                        end
                        PH_SID: begin
                            r_sid <= in_ch.rx_byte;
                            r_ph <= PH_D0;
                        end
                        PH_D0: begin r_digits <= {r_digits[15:0], in_ch.rx_byte}; r_ph <= PH_D1; end
                        PH_D1: begin r_digits <= {r_digits[15:0], in_ch.rx_byte}; r_ph <= PH_D2; end
                        PH_D2: begin r_digits <= {r_digits[15:0], in_ch.rx_byte}; r_ph <= PH_END; end
                        default: begin
                            r_ph <= PH_HUNT;
                            // check checksum and end symbol, then build the field program for this command
                            if (r_digits != {ChZero + 8'(want_d[11:8]),
                                             ChZero + 8'(want_d[7:4]),
                                             ChZero + 8'(want_d[3:0])}) begin
                                r_ost <= StSum; r_st <= S_ERR;
                            end else if (in_ch.rx_byte != r_end) begin
                                r_ost <= StEnd; r_st <= S_ERR;
                            end else if (r_cmd == ChA) begin
                                r_st <= S_ITEM;
                                r_tr[r_ts] <= t_in; r_ts <= nxt(r_ts);
                                r_hr[r_hs] <= h_in; r_hs <= nxt(r_hs);
                                r_cr[r_cs] <= in_ch.co2_level; r_cs <= nxt(r_cs);
                                r_fk[0] <= FK_CHAR;   r_fv[0] <= {7'd0, ChA};
                                r_fk[1] <= FK_CHAR;   r_fv[1] <= {7'd0, ChT};
                                r_fk[2] <= FK_SIGNED; r_fv[2] <= {7'd0, t_in};
                                r_fk[3] <= FK_CHAR;   r_fv[3] <= {7'd0, ChH};
                                r_fk[4] <= FK_SIGNED; r_fv[4] <= {7'd0, h_in};
                                r_fk[5] <= FK_CHAR;   r_fv[5] <= {7'd0, ChC};
                                r_fk[6] <= FK_CO2;    r_fv[6] <= in_ch.co2_level;
                                r_fk[7] <= FK_SUM;    r_fv[7] <= '0;
                                r_nf <= 6'd8;
                            end else if (r_cmd == ChP && (r_sid == ChT || r_sid == ChH ||
                                                          r_sid == ChC)) begin
                                r_st <= S_ITEM;
                                r_fk[0] <= FK_CHAR; r_fv[0] <= {7'd0, ChP};
                                r_fk[1] <= FK_CHAR; r_fv[1] <= {7'd0, r_sid};
                                r_fk[3] <= FK_SUM;  r_fv[3] <= '0;
                                r_nf <= 6'd4;
                                if (r_sid == ChT) begin
                                    r_tr[r_ts] <= t_in; r_ts <= nxt(r_ts);
                                    r_fk[2] <= FK_SIGNED; r_fv[2] <= {7'd0, t_in};
                                end else if (r_sid == ChH) begin
                                    r_hr[r_hs] <= h_in; r_hs <= nxt(r_hs);
                                    r_fk[2] <= FK_SIGNED; r_fv[2] <= {7'd0, h_in};
                                end else begin
                                    r_cr[r_cs] <= in_ch.co2_level; r_cs <= nxt(r_cs);
                                    r_fk[2] <= FK_CO2; r_fv[2] <= in_ch.co2_level;
                                end
                            end else if (r_cmd == ChP) begin
                                r_ost <= StUnkn; r_st <= S_ERR;
                            end else if (r_cmd == ChL) begin
                                r_st <= S_ITEM;
                                for (int g = 0; g < 3; g++) begin
                                    r_fk[g*(HISTORY_DEPTH+3)]   <= FK_CHAR;
                                    r_fv[g*(HISTORY_DEPTH+3)]   <= {7'd0, ChL};
                                    r_fk[g*(HISTORY_DEPTH+3)+1] <= FK_CHAR;
                                    r_fv[g*(HISTORY_DEPTH+3)+1] <= {7'd0,
                                        (g == 0) ? ChT : (g == 1) ? ChH : ChC};
                                    r_fk[g*(HISTORY_DEPTH+3)+HISTORY_DEPTH+2] <= FK_SUM;
                                    r_fv[g*(HISTORY_DEPTH+3)+HISTORY_DEPTH+2] <= '0;
                                end
                                for (int j = 0; j < HISTORY_DEPTH; j++) begin
                                    r_fk[2+j] <= FK_SIGNED;
                                    r_fv[2+j] <= {7'd0, r_tr[ring_at(r_ts, j)]};
                                    r_fk[HISTORY_DEPTH+5+j] <= FK_SIGNED;
                                    r_fv[HISTORY_DEPTH+5+j] <=
                                        {7'd0, r_hr[ring_at(r_hs, j)]};
                                    r_fk[2*HISTORY_DEPTH+8+j] <= FK_CO2;
                                    r_fv[2*HISTORY_DEPTH+8+j] <= r_cr[ring_at(r_cs, j)];
                                end
                                r_nf <= 6'(3*HISTORY_DEPTH+9);
                            end else if (r_cmd == ChR) begin
                                r_st <= S_ITEM;
                                for (int i = 0; i < HISTORY_DEPTH; i++) begin
                                    r_tr[i] <= '0; r_hr[i] <= '0; r_cr[i] <= '0;
                                end
                                r_ts <= '0; r_hs <= '0; r_cs <= '0;
                                r_fk[0] <= FK_CHAR; r_fv[0] <= {7'd0, ChR};
                                r_fk[1] <= FK_SUM;  r_fv[1] <= '0;
                                r_nf <= 6'd2;
                            end else begin
                                r_ost <= StUnkn; r_st <= S_ERR;
                            end
                        end
                    endcase
                end
                S_ERR: if (free) begin
                    r_ob <= '0; r_olast <= 1'b1; r_ovalid <= 1'b1;
                    r_st <= S_IDLE;
                end
                S_ITEM: begin
                    r_fi <= '0; r_sub <= '0; r_cnt <= '0; r_sum <= '0;
                    r_st <= (r_nf == 6'd0) ? S_IDLE : S_NEXT;
                end
                S_NEXT: if (free) begin
                    // frame open
                    r_ob <= ChHash; r_ost <= StOk; r_olast <= 1'b0; r_ovalid <= 1'b1;
                    r_cnt <= r_cnt + 6'd1; r_sum <= '0;
                    r_st <= S_LOAD;
                end
                S_LOAD: begin
                    r_d3 <= dec3(r_sum);
                    r_st <= (fk == FK_SIGNED || fk == FK_CO2) ? S_DIG : S_OUT;
                end
                S_DIG: if (dig_done) r_st <= S_OUT;
                default: if (free) begin
                    r_ob <= ob; r_ost <= StOk; r_olast <= is_final; r_ovalid <= 1'b1;
                    r_cnt <= cnt_n;
                    if (body) r_sum <= r_sum + ob;
                    if (is_final) begin
                        r_st <= S_IDLE;
                    end else if (r_sub + 3'd1 == flen) begin
                        r_sub <= '0;
                        r_fi <= r_fi + 6'd1;
                        r_st <= (fk == FK_SUM) ? S_NEXT : S_LOAD;
                    end else begin
                        r_sub <= r_sub + 3'd1;
                        r_st <= (fk == FK_SUM) ? S_OUT : S_DIG;
                    end
                end
            endcase
        end
    end
endmodule

### rtl/scfr_checker.sv
// checker: port level properties of the responder
module scfr_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] out_byte,
    input logic [1:0] out_status,
    input logic       out_last
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_byte))
        else $error("output word dropped under stall");
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && out_status != 2'd0 |-> out_byte == 8'd0 && out_last)
        else $error("error word not zero or not last");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_last |-> !in_ready)
        else $error("input taken mid response");
    a_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_valid && in_ready |=> !out_valid)
        else $error("word emitted in the cycle after accept");
endmodule

bind sensor_command_frame_responder_unit scfr_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .out_byte(out_ch.tx_byte), .out_status(out_ch.status), .out_last(out_ch.last)
);
